// File: hdl/first_order_masked_gadget_unit_assert.svh
`ifndef FIRST_ORDER_MASKED_GADGET_UNIT_ASSERT_SVH
`define FIRST_ORDER_MASKED_GADGET_UNIT_ASSERT_SVH

// concurrent check, off while reset is high
`define FOMG_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("fomg check failed");

// concurrent check, also active around reset
`define FOMG_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("fomg check failed");

`endif

// File: hdl/fomg_pkg.sv
package fomg_pkg;

  localparam int unsigned W = 16;
  localparam int unsigned A2B_ROUNDS_PER_STAGE = 5;

  typedef logic [W-1:0] word_t;

  typedef enum logic [2:0] {
    MODE_A2B  = 3'd0,
    MODE_B2A  = 3'd1,
    MODE_AND  = 3'd2,
    MODE_ADD  = 3'd3,
    MODE_ZERO = 3'd4
  } mode_t;

  typedef struct packed {
    word_t s0;
    word_t s1;
  } pair_t;

  typedef struct packed {
    word_t t;
    word_t om;
  } a2b_t;

  // Goubin carry rounds, A2B_ROUNDS_PER_STAGE of them
  function automatic a2b_t a2b_rounds(input a2b_t st, input word_t a0, input word_t a1);
    a2b_t  r;
    word_t g;
    r = st;
    for (int k = 0; k < A2B_ROUNDS_PER_STAGE; k++) begin
      g   = (r.t & a1) ^ r.om;
      r.t = r.t & a0;
      g   = g ^ r.t;
      r.t = g << 1;
    end
    return r;
  endfunction

  function automatic pair_t b2a(input word_t b0, input word_t b1, input word_t g);
    word_t t;
    word_t g2;
    word_t v;
    pair_t r;
    t    = ((b0 ^ g) - g) ^ b0;
    g2   = g ^ b1;
    v    = (b0 ^ g2) - g2;
    r.s0 = v ^ t;
    r.s1 = b1;
    return r;
  endfunction

  function automatic pair_t isw_and(input pair_t x, input pair_t y, input word_t r);
    pair_t z;
    z.s0 = (x.s0 & y.s0) ^ r;
    z.s1 = (x.s1 & y.s1) ^ r ^ (x.s0 & y.s1) ^ (x.s1 & y.s0);
    return z;
  endfunction

  function automatic pair_t zt_round(input pair_t o, input int unsigned sh,
                                     input word_t r, input word_t rr);
    pair_t z;
    z.s0 = (o.s0 >> sh) ^ r;
    z.s1 = (o.s1 >> sh) ^ r;
    return isw_and(z, o, rr);
  endfunction

endpackage

// File: hdl/first_order_masked_gadget_unit.sv
// channel | dir | tdata (low bit up)                          | tuser
// s_axis  | in  | a_share0 a_share1 b_share0 b_share1 rand_lo  | mode
//         |     | rand_hi rand_last (208 bits)                 |
// m_axis  | out | out_share0 out_share1 (32 bits)              | -
// Four register stages (s1, s2, s3, out); one transfer per cycle while m_axis_tready does not stall.
// The 15 carry rounds of arith-to-bool set the depth: five per stage.
// rst is synchronous and clears the stage valid bits only.
// Each stage moves when it is empty or the next one moves, so bubbles
// close up under a stall and nothing is dropped or repeated.
module first_order_masked_gadget_unit (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [207:0] s_axis_tdata,   // a_share0 a_share1 b_share0 b_share1 rand_lo rand_hi rand_last
  input  logic [2:0]   s_axis_tuser,   // mode
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [31:0]  m_axis_tdata    // out_share0 out_share1
);

  typedef struct packed {
    logic [2:0]              mode;
    fomg_pkg::pair_t         u;
    fomg_pkg::pair_t         v;
    fomg_pkg::word_t         rnd;
    logic [5*fomg_pkg::W-1:0] zr;
  } st1_t;

  typedef struct packed {
    logic [2:0]      mode;
    fomg_pkg::a2b_t  ab;
    fomg_pkg::pair_t a;
    fomg_pkg::word_t y0;
    fomg_pkg::pair_t res;
  } st2_t;

  logic v1, v2, v3, v4;
  logic en1, en2, en3, en4;
  st1_t s1, s1_next;
  st2_t s2, s2_next, s3, s3_next;
  fomg_pkg::pair_t out, out_next;

  assign en4 = !v4 || m_axis_tready;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign s_axis_tready = en1;
  assign m_axis_tvalid = v4;
  assign m_axis_tdata  = {out.s1, out.s0};

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (en1) v1 <= s_axis_tvalid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) s1 <= s1_next;
    if (en2) s2 <= s2_next;
    if (en3) s3 <= s3_next;
    if (en4) out <= out_next;
  end

  // stage 1: bool-to-arith, AND, first two zero-test rounds
  always_comb begin
    fomg_pkg::pair_t x, y, o;
    fomg_pkg::word_t r [0:8];
    x.s0 = s_axis_tdata[15:0];
    x.s1 = s_axis_tdata[31:16];
    y.s0 = s_axis_tdata[47:32];
    y.s1 = s_axis_tdata[63:48];
    for (int i = 0; i < 8; i++) r[i] = s_axis_tdata[64 + 16*i +: 16];
    r[8] = s_axis_tdata[207:192];
    s1_next      = '0;
    s1_next.mode = s_axis_tuser;
    s1_next.zr   = s_axis_tdata[207:128];
    o.s0 = ~x.s0;
    o.s1 = x.s1;
    unique case (s_axis_tuser)
      fomg_pkg::MODE_A2B: begin
        s1_next.u   = x;
        s1_next.rnd = r[0];
      end
      fomg_pkg::MODE_B2A: s1_next.u = fomg_pkg::b2a(x.s0, x.s1, r[0]);
      fomg_pkg::MODE_AND: s1_next.u = fomg_pkg::isw_and(x, y, r[0]);
      fomg_pkg::MODE_ADD: begin
        s1_next.u   = fomg_pkg::b2a(x.s0, x.s1, r[0]);
        s1_next.v   = fomg_pkg::b2a(y.s0, y.s1, r[1]);
        s1_next.rnd = r[2];
      end
      fomg_pkg::MODE_ZERO: begin
        o = fomg_pkg::zt_round(o, 1, r[0], r[1]);
        s1_next.u = fomg_pkg::zt_round(o, 2, r[2], r[3]);
      end
      default: s1_next.u = '0;
    endcase
  end

  // stage 2: share sum, A2B prologue and rounds 1-5, zero-test finish
  always_comb begin
    fomg_pkg::pair_t a, o;
    fomg_pkg::word_t g, y0a, g2;
    fomg_pkg::a2b_t  ab;
    s2_next      = '0;
    s2_next.mode = s1.mode;
    a = s1.u;
    if (s1.mode == fomg_pkg::MODE_ADD) begin
      a.s0 = s1.u.s0 + s1.v.s0;
      a.s1 = s1.u.s1 + s1.v.s1;
    end
    g     = s1.rnd;
    ab.t  = g << 1;
    y0a   = g ^ a.s1;
    ab.om = g & y0a;
    s2_next.y0 = ab.t ^ a.s0;
    g2    = (g ^ s2_next.y0) & a.s1;
    ab.om = ab.om ^ g2 ^ (ab.t & a.s0);
    s2_next.ab = fomg_pkg::a2b_rounds(ab, a.s0, a.s1);
    s2_next.a  = a;
    o = fomg_pkg::zt_round(s1.u, 4, s1.zr[15:0], s1.zr[31:16]);
    o = fomg_pkg::zt_round(o, 8, s1.zr[47:32], s1.zr[63:48]);
    if (s1.mode == fomg_pkg::MODE_ZERO) begin
      s2_next.res.s0 = {{(fomg_pkg::W-1){1'b0}}, o.s0[0]} ^ s1.zr[79:64];
      s2_next.res.s1 = {{(fomg_pkg::W-1){1'b0}}, o.s1[0]} ^ s1.zr[79:64];
    end else begin
      s2_next.res = s1.u;
    end
  end

  // stage 3: rounds 6-10
  always_comb begin
    s3_next    = s2;
    s3_next.ab = fomg_pkg::a2b_rounds(s2.ab, s2.a.s0, s2.a.s1);
  end

  // stage 4: rounds 11-15 and output select
  always_comb begin
    fomg_pkg::a2b_t ab;
    ab = fomg_pkg::a2b_rounds(s3.ab, s3.a.s0, s3.a.s1);
    unique case (s3.mode)
      fomg_pkg::MODE_A2B, fomg_pkg::MODE_ADD: begin
        out_next.s0 = s3.y0 ^ ab.t;
        out_next.s1 = s3.a.s1;
      end
      fomg_pkg::MODE_B2A, fomg_pkg::MODE_AND, fomg_pkg::MODE_ZERO: out_next = s3.res;
      default: out_next = '0;
    endcase
  end

endmodule

// File: hdl/fomg_chk.sv
`include "first_order_masked_gadget_unit_assert.svh"

module fomg_chk (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata
);

  `FOMG_ASSERT(a_ready_when_empty, clk, rst, !m_axis_tvalid |-> s_axis_tready)
  `FOMG_ASSERT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
  `FOMG_ASSERT_ALWAYS(a_reset_empty, clk, $past(rst) |-> !m_axis_tvalid)
  `FOMG_ASSERT(a_ready_follows_sink, clk, rst, m_axis_tready |-> s_axis_tready)

endmodule

bind first_order_masked_gadget_unit fomg_chk u_fomg_chk (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// File: test/first_order_masked_gadget_unit_tb.sv
module first_order_masked_gadget_unit_tb;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [2:0]  mode;
    logic [15:0] xa0, xa1, yb0, yb1;
    logic [63:0] rnd_lo, rnd_hi;
    logic [15:0] rnd_last;
  } gadget_req_t;

  typedef struct {
    logic [15:0] s0, s1;
  } share_pair_t;

  localparam int CYCLE_LIMIT = 400000;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [207:0] s_axis_tdata = '0;
  logic [2:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [31:0]  m_axis_tdata;

  gadget_req_t req_q[$];
  share_pair_t expected_q[$];
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  bit          hold_send = 1'b0;
  bit          in_taken = 1'b0;
  int          error_count = 0;
  int          cycle_count = 0;

  first_order_masked_gadget_unit uut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  always #5 clk = ~clk;

  function automatic logic [15:0] rnd_word(gadget_req_t r, int i);
    logic [15:0] w;
    if (i < 4) w = r.rnd_lo[16*i +: 16];
    else if (i < 8) w = r.rnd_hi[16*(i-4) +: 16];
    else w = r.rnd_last;
    return w;
  endfunction

  function automatic share_pair_t goubin_a2b(logic [15:0] a0, logic [15:0] a1,
                                             logic [15:0] g);
    logic [15:0] t, om, y0, gg;
    share_pair_t r;
    gg = g;
    t  = gg << 1;
    y0 = gg ^ a1;
    om = gg & y0;
    y0 = t ^ a0;
    gg = (gg ^ y0) & a1;
    om = om ^ gg ^ (t & a0);
    for (int k = 1; k < 16; k++) begin
      gg = (t & a1) ^ om;
      t  = t & a0;
      gg = gg ^ t;
      t  = gg << 1;
    end
    r.s0 = y0 ^ t;
    r.s1 = a1;
    return r;
  endfunction

  function automatic share_pair_t goubin_b2a(logic [15:0] b0, logic [15:0] b1,
                                             logic [15:0] g);
    logic [15:0] t, g2, v;
    share_pair_t r;
    t    = ((b0 ^ g) - g) ^ b0;
    g2   = g ^ b1;
    v    = (b0 ^ g2) - g2;
    r.s0 = v ^ t;
    r.s1 = b1;
    return r;
  endfunction

  function automatic share_pair_t masked_and(share_pair_t x, share_pair_t y,
                                             logic [15:0] r);
    share_pair_t z;
    z.s0 = (x.s0 & y.s0) ^ r;
    z.s1 = (x.s1 & y.s1) ^ r ^ (x.s0 & y.s1) ^ (x.s1 & y.s0);
    return z;
  endfunction

  function automatic share_pair_t gadget_result(gadget_req_t r);
    share_pair_t x, y, ax, ay, res, z;
    logic [15:0] rr;
    x.s0 = r.xa0; x.s1 = r.xa1;
    y.s0 = r.yb0; y.s1 = r.yb1;
    res.s0 = '0; res.s1 = '0;
    case (r.mode)
      fomg_pkg::MODE_A2B: res = goubin_a2b(x.s0, x.s1, rnd_word(r, 0));
      fomg_pkg::MODE_B2A: res = goubin_b2a(x.s0, x.s1, rnd_word(r, 0));
      fomg_pkg::MODE_AND: res = masked_and(x, y, rnd_word(r, 0));
      fomg_pkg::MODE_ADD: begin
        ax  = goubin_b2a(x.s0, x.s1, rnd_word(r, 0));
        ay  = goubin_b2a(y.s0, y.s1, rnd_word(r, 1));
        res = goubin_a2b(ax.s0 + ay.s0, ax.s1 + ay.s1, rnd_word(r, 2));
      end
      fomg_pkg::MODE_ZERO: begin
        // 16 is a power of two, so no padding above the word
        res.s0 = ~x.s0;
        res.s1 = x.s1;
        for (int i = 0; i < 4; i++) begin
          rr   = rnd_word(r, 2*i);
          z.s0 = (res.s0 >> (1 << i)) ^ rr;
          z.s1 = (res.s1 >> (1 << i)) ^ rr;
          res  = masked_and(z, res, rnd_word(r, 2*i + 1));
        end
        rr     = rnd_word(r, 8);
        res.s0 = {15'd0, res.s0[0]} ^ rr;
        res.s1 = {15'd0, res.s1[0]} ^ rr;
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic logic [15:0] rand_word16();
    case ($urandom_range(0, 5))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic push_req(logic [2:0] mode, logic [15:0] a0, logic [15:0] a1,
                          logic [15:0] b0, logic [15:0] b1, bit rand_fill);
    gadget_req_t r;
    r.mode = mode;
    r.xa0 = a0; r.xa1 = a1; r.yb0 = b0; r.yb1 = b1;
    if (rand_fill) begin
      r.rnd_lo   = {$urandom, $urandom};
      r.rnd_hi   = {$urandom, $urandom};
      r.rnd_last = rand_word16();
    end else begin
      r.rnd_lo = '0; r.rnd_hi = '0; r.rnd_last = '0;
    end
    req_q.push_back(r);
  endtask

  task automatic push_random(int n);
    logic [15:0] x, m;
    int md;
    for (int i = 0; i < n; i++) begin
      md = $urandom_range(0, 19);
      md = (md < 18) ? md % 5 : 5 + (md - 18) * 2;
      m  = rand_word16();
      x  = $urandom_range(0, 3) == 0 ? 16'h0000 : rand_word16();
      // zero test: often pass real shares of zero
      if (md == fomg_pkg::MODE_ZERO && $urandom_range(0, 1) == 0) x = '0;
      push_req(3'(md), (md == fomg_pkg::MODE_A2B) ? x - m : x ^ m, m,
               rand_word16(), rand_word16(), 1'b1);
    end
  endtask

  task automatic drain();
    while (req_q.size() != 0 || expected_q.size() != 0) @(posedge clk);
  endtask

  always @(negedge clk) begin
    if (!rst) begin
      if (!s_axis_tvalid || in_taken) begin
        if (req_q.size() != 0 && !hold_send &&
            $urandom_range(0, 99) >= send_idle_pct) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tuser  <= req_q[0].mode;
          s_axis_tdata  <= {req_q[0].rnd_last, req_q[0].rnd_hi, req_q[0].rnd_lo,
                            req_q[0].yb1, req_q[0].yb0, req_q[0].xa1, req_q[0].xa0};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    share_pair_t e;
    gadget_req_t r;
    cycle_count <= cycle_count + 1;
    in_taken <= !rst && s_axis_tvalid && s_axis_tready;
    if (!rst && s_axis_tvalid && s_axis_tready) begin
      r = req_q.pop_front();
      expected_q.push_back(gadget_result(r));
    end
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_q.size() == 0) begin
        $error("unexpected result transfer %h", m_axis_tdata);
        error_count = error_count + 1;
      end else begin
        e = expected_q.pop_front();
        if (m_axis_tdata[15:0] !== e.s0) begin
          $error("out_share0 expected %h actual %h", e.s0, m_axis_tdata[15:0]);
          error_count = error_count + 1;
        end
        if (m_axis_tdata[31:16] !== e.s1) begin
          $error("out_share1 expected %h actual %h", e.s1, m_axis_tdata[31:16]);
          error_count = error_count + 1;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk) rst = 1'b0;

    for (int md = 0; md < 8; md++) begin
      push_req(3'(md), 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0);
      push_req(3'(md), 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
    end
    push_req(fomg_pkg::MODE_ZERO, 16'h1234, 16'h1234, 0, 0, 1'b1);
    push_req(fomg_pkg::MODE_ZERO, 16'h1235, 16'h1234, 0, 0, 1'b1);
    push_req(fomg_pkg::MODE_A2B, 16'h8000, 16'h8000, 0, 0, 1'b1);
    push_req(fomg_pkg::MODE_ADD, 16'hFFFF, 16'h0000, 16'h0001, 16'h0000, 1'b1);
    drain();

    send_idle_pct = 0;  recv_stall_pct = 0;  push_random(140); drain();
    send_idle_pct = 79; recv_stall_pct = 0;  push_random(130); drain();
    send_idle_pct = 0;  recv_stall_pct = 79; push_random(130); drain();
    send_idle_pct = 34; recv_stall_pct = 34; push_random(70);
    hold_send = 1'b1;
    while (expected_q.size() != 0) @(posedge clk);
    hold_send = 1'b0;
    push_random(70);
    drain();
    send_idle_pct = 0; recv_stall_pct = 0;
    repeat (20) @(posedge clk);

    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
